FILE: rtl/core/crspl_pkg.sv
// Shared types, constants and the output rounding function of the spline evaluator.
`timescale 1ns / 1ps
`default_nettype none

package crspl_pkg;

   // Fixed field widths and fixed-point formats.
   localparam int T_FRAC_BITS = 16;
   localparam int T_W         = 22;
   localparam int COORD_W     = 24;
   localparam int OUT_W       = 32;
   localparam int WGT_W       = T_FRAC_BITS + 5;
   localparam int PROD_W      = COORD_W + WGT_W;
   localparam int PAIR_W      = PROD_W + 1;
   localparam int SUM_W       = PROD_W + 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Item kinds.
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_POS   = 2'd1,
      KIND_GRAD  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // Configuration register indexes.
   typedef enum logic {
      REG_POINTS = 1'b0,
      REG_LOOPED = 1'b1
   } reg_index_type;

   // One evaluation handed from the front end to the back end.
   typedef struct packed {
      logic                           err;
      logic [3:0][WGT_W-1:0]          wgt;
      logic [3:0][COORD_W-1:0]        px;
      logic [3:0][COORD_W-1:0]        py;
   } entry_type;

   // Halve and drop the 16 fraction bits with round half up, then saturate to the 32-bit output range.
   function automatic logic [OUT_W-1:0] finish_sum(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W:0] b;
      logic signed [SUM_W:0] r;
      logic [OUT_W-1:0]      res;
      b = (SUM_W+1)'(s) + (SUM_W+1)'(1 << T_FRAC_BITS);
      r = b >>> (T_FRAC_BITS + 1);
      if (r[SUM_W:OUT_W-1] == '0 || r[SUM_W:OUT_W-1] == '1) begin
         res = r[OUT_W-1:0];
      end else if (r[SUM_W]) begin
         res = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(OUT_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/crspl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module crspl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/crspl_front.sv
// Front end: decodes items, stores points, picks neighbors and builds basis weights.
`timescale 1ns / 1ps
`default_nettype none

module crspl_front
   import crspl_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_accept,
   input  wire logic [1:0]         req_kind,
   input  wire logic [5:0]         req_point_index,
   input  wire logic [COORD_W-1:0] req_coord_x,
   input  wire logic [COORD_W-1:0] req_coord_y,
   input  wire logic [T_W-1:0]     req_t_pos,
   input  wire logic [6:0]         cfg_points,
   input  wire logic               cfg_looped,
   output logic                    enq_valid,
   output entry_type               enq_entry,
   output logic [1:0]              inflight
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam logic [6:0] N_MAX = (MAX_POINTS > 127) ? 7'd127 : 7'(MAX_POINTS);
   localparam logic [32:0] HALF = 33'(1 << (T_FRAC_BITS - 1));
   localparam logic signed [WGT_W-1:0] ONE = WGT_W'(1 << T_FRAC_BITS);

   logic                           is_eval;
   logic                           do_write;
   logic [6:0]                     n_use;
   logic [7:0]                     n8;
   logic [7:0]                     ip8;
   logic [3:0][7:0]                pidx;
   logic                           idx_err;
   logic [3:0][IDX_W-1:0]          addr;
   logic [T_FRAC_BITS-1:0]         u_in;
   logic [32:0]                    tt_sum;
   logic [16:0]                    tt;
   logic [33:0]                    ttt_sum;
   logic signed [WGT_W-1:0]        s_u;
   logic signed [WGT_W-1:0]        s_tt;
   logic signed [WGT_W-1:0]        s_ttt;
   logic [3:0][2*COORD_W-1:0]      rd_data;

   logic                           v_a_ff, v_a_in;
   logic                           grad_a_ff, grad_a_in;
   logic                           err_a_ff, err_a_in;
   logic [T_FRAC_BITS-1:0]         u_a_ff, u_a_in;
   logic [31:0]                    uu_a_ff, uu_a_in;
   logic [3:0][IDX_W-1:0]          addr_a_ff, addr_a_in;
   logic                           v_b_ff, v_b_in;
   logic                           grad_b_ff, grad_b_in;
   logic                           err_b_ff, err_b_in;
   logic [T_FRAC_BITS-1:0]         u_b_ff, u_b_in;
   logic [16:0]                    tt_b_ff, tt_b_in;
   logic [32:0]                    ttu_b_ff, ttu_b_in;

   // Decode the item and clamp the point count.
   assign is_eval  = req_accept && (req_kind == KIND_POS || req_kind == KIND_GRAD);
   assign do_write = req_accept && (req_kind == KIND_WRITE) &&
                     (int'(req_point_index) < MAX_POINTS);
   assign n_use = (cfg_points < 7'd4) ? 7'd4 :
                  (cfg_points > N_MAX) ? N_MAX : cfg_points;
   assign n8    = {1'b0, n_use};
   assign ip8   = {2'b00, req_t_pos[T_W-1:T_FRAC_BITS]};
   assign u_in  = req_t_pos[T_FRAC_BITS-1:0];

   // Neighbor indices and range check.
   always_comb begin
      if (cfg_looped) begin
         idx_err = (ip8 >= n8);
         pidx[1] = ip8;
         pidx[2] = (ip8 + 8'd1 == n8) ? 8'd0 : ip8 + 8'd1;
         pidx[3] = (pidx[2] + 8'd1 == n8) ? 8'd0 : pidx[2] + 8'd1;
         pidx[0] = (ip8 != 8'd0) ? ip8 - 8'd1 : n8 - 8'd1;
      end else begin
         idx_err = (ip8 + 8'd3 >= n8);
         pidx[0] = ip8;
         pidx[1] = ip8 + 8'd1;
         pidx[2] = ip8 + 8'd2;
         pidx[3] = ip8 + 8'd3;
      end
      for (int k = 0; k < 4; k++) begin
         addr[k] = IDX_W'(pidx[k]);
      end
   end

   // Stage A: square of the fraction and the read addresses.
   assign v_a_in    = is_eval;
   assign grad_a_in = (req_kind == KIND_GRAD);
   assign err_a_in  = idx_err;
   assign u_a_in    = u_in;
   assign uu_a_in   = {16'd0, u_in} * {16'd0, u_in};
   assign addr_a_in = addr;

   // Stage B: rounded square and the cube product.
   assign tt_sum    = {1'b0, uu_a_ff} + HALF;
   assign tt        = tt_sum[32:T_FRAC_BITS];
   assign v_b_in    = v_a_ff;
   assign grad_b_in = grad_a_ff;
   assign err_b_in  = err_a_ff;
   assign u_b_in    = u_a_ff;
   assign tt_b_in   = tt;
   assign ttu_b_in  = {16'd0, tt} * {17'd0, u_a_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
      end else begin
         v_a_ff <= v_a_in;
         v_b_ff <= v_b_in;
      end
      grad_a_ff <= grad_a_in;
      err_a_ff  <= err_a_in;
      u_a_ff    <= u_a_in;
      uu_a_ff   <= uu_a_in;
      addr_a_ff <= addr_a_in;
      grad_b_ff <= grad_b_in;
      err_b_ff  <= err_b_in;
      u_b_ff    <= u_b_in;
      tt_b_ff   <= tt_b_in;
      ttu_b_ff  <= ttu_b_in;
   end

   // One point store per neighbor so all four are read in the same cycle.
   for (genvar g = 0; g < 4; g++) begin : g_store
      crspl_ram #(
         .WIDTH (2 * COORD_W),
         .DEPTH (MAX_POINTS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (do_write),
         .wr_addr (IDX_W'(req_point_index)),
         .wr_data ({req_coord_y, req_coord_x}),
         .rd_addr (addr_a_ff[g]),
         .rd_data (rd_data[g])
      );
   end

   // Basis weights from u, tt and ttt.
   assign ttt_sum = {1'b0, ttu_b_ff} + 34'(HALF);
   assign s_u     = $signed(WGT_W'(u_b_ff));
   assign s_tt    = $signed(WGT_W'(tt_b_ff));
   assign s_ttt   = $signed(WGT_W'(ttt_sum[33:T_FRAC_BITS]));

   always_comb begin
      enq_entry.err = err_b_ff;
      if (grad_b_ff) begin
         enq_entry.wgt[0] = WGT_W'(-(s_tt * 3) + (s_u * 4) - ONE);
         enq_entry.wgt[1] = WGT_W'((s_tt * 9) - (s_u * 10));
         enq_entry.wgt[2] = WGT_W'(-(s_tt * 9) + (s_u * 8) + ONE);
         enq_entry.wgt[3] = WGT_W'((s_tt * 3) - (s_u * 2));
      end else begin
         enq_entry.wgt[0] = WGT_W'(-s_ttt + (s_tt * 2) - s_u);
         enq_entry.wgt[1] = WGT_W'((s_ttt * 3) - (s_tt * 5) + (ONE * 2));
         enq_entry.wgt[2] = WGT_W'(-(s_ttt * 3) + (s_tt * 4) + s_u);
         enq_entry.wgt[3] = WGT_W'(s_ttt - s_tt);
      end
      for (int k = 0; k < 4; k++) begin
         enq_entry.px[k] = rd_data[k][COORD_W-1:0];
         enq_entry.py[k] = rd_data[k][2*COORD_W-1:COORD_W];
      end
   end

   assign enq_valid = v_b_ff;
   assign inflight  = {1'b0, v_a_ff} + {1'b0, v_b_ff};

endmodule

`default_nettype wire

FILE: rtl/core/crspl_queue.sv
// Short queue of prepared evaluations between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module crspl_queue
   import crspl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire entry_type         wr_entry,
   input  wire logic              rd_en,
   output entry_type              rd_entry,
   output logic                   not_empty,
   output logic [QCNT_W-1:0]      count
);

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     head_ff, head_in;
   logic [QPTR_W-1:0]     tail_ff, tail_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      head_in  = rd_en ? head_ff + 1'b1 : head_ff;
      tail_in  = wr_en ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + QCNT_W'(wr_en) - QCNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (wr_en) begin
         slot_ff[tail_ff] <= wr_entry;
      end
   end

   assign rd_entry  = slot_ff[head_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

FILE: rtl/core/crspl_back.sv
// Back end: weighted sums of the four points, rounding, saturation and result register.
`timescale 1ns / 1ps
`default_nettype none

module crspl_back
   import crspl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire entry_type         in_entry,
   output logic                   in_ready,
   input  wire logic              out_pop,
   output logic                   out_valid,
   output logic [OUT_W-1:0]       out_x,
   output logic [OUT_W-1:0]       out_y,
   output logic                   out_status
);

   logic                               rdy1, rdy2, rdy3;
   logic                               v1_ff, v1_in;
   logic                               err1_ff;
   logic signed [3:0][PROD_W-1:0]      px1_ff, px1_in;
   logic signed [3:0][PROD_W-1:0]      py1_ff, py1_in;
   logic                               v2_ff, v2_in;
   logic                               err2_ff;
   logic signed [1:0][PAIR_W-1:0]      sx2_ff, sx2_in;
   logic signed [1:0][PAIR_W-1:0]      sy2_ff, sy2_in;
   logic                               v3_ff, v3_in;
   logic                               st3_ff;
   logic [OUT_W-1:0]                   x3_ff, x3_in;
   logic [OUT_W-1:0]                   y3_ff, y3_in;

   // Each stage moves when the one after it has room.
   assign rdy3     = !v3_ff || out_pop;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   // Products of points and weights.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         px1_in[k] = PROD_W'($signed(in_entry.px[k])) * PROD_W'($signed(in_entry.wgt[k]));
         py1_in[k] = PROD_W'($signed(in_entry.py[k])) * PROD_W'($signed(in_entry.wgt[k]));
      end
   end

   // Pair sums.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         sx2_in[k] = PAIR_W'($signed(px1_ff[2*k])) + PAIR_W'($signed(px1_ff[2*k+1]));
         sy2_in[k] = PAIR_W'($signed(py1_ff[2*k])) + PAIR_W'($signed(py1_ff[2*k+1]));
      end
   end

   // Final sum, halving with rounding, saturation; an index error gives zeros.
   assign x3_in = err2_ff ? '0 :
                  finish_sum(SUM_W'($signed(sx2_ff[0])) + SUM_W'($signed(sx2_ff[1])));
   assign y3_in = err2_ff ? '0 :
                  finish_sum(SUM_W'($signed(sy2_ff[0])) + SUM_W'($signed(sy2_ff[1])));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      if (rdy1) begin
         err1_ff <= in_entry.err;
         px1_ff  <= px1_in;
         py1_ff  <= py1_in;
      end
      if (rdy2) begin
         err2_ff <= err1_ff;
         sx2_ff  <= sx2_in;
         sy2_ff  <= sy2_in;
      end
      if (rdy3) begin
         st3_ff <= err2_ff;
         x3_ff  <= x3_in;
         y3_ff  <= y3_in;
      end
   end

   assign out_valid  = v3_ff;
   assign out_x      = x3_ff;
   assign out_y      = y3_ff;
   assign out_status = st3_ff;

endmodule

`default_nettype wire

FILE: rtl/core/catmull_rom_spline_eval_unit.sv
// Top level of the Catmull-Rom spline evaluator: ports, registers and glue.
//
// Usage: items enter as a queue push (push, full). A write item stores one
// control point in every copy of the point store and gives no result. A
// position or gradient item gives one result (out_x, out_y, status), read
// from the result side as a queue pop (empty, pop). Kind code 3 is dropped.
// One item is taken every cycle while full is low: the front end
// is a fixed two-stage pipeline over four replicated point stores with one
// read port each, and the back end is a three-stage multiply-and-add pipe.
// The front end never stalls; push is refused (full) once the items in its
// two stages plus those in the four-entry queue fill the queue. When pop is
// held low the back end stops, the queue fills and full rises.
// Reset clears all control state and sets points_in_use to 4 and looped to
// 0. Stored points are undefined until written. Configuration writes take
// effect on the next cycle; the user must make them only while the block is
// idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_spline_eval_unit
   import crspl_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [1:0]         req_kind,
   input  wire logic [5:0]         req_point_index,
   input  wire logic [COORD_W-1:0] req_coord_x,
   input  wire logic [COORD_W-1:0] req_coord_y,
   input  wire logic [T_W-1:0]     req_t_pos,
   output logic                    empty,
   input  wire logic               pop,
   output logic [OUT_W-1:0]        rsp_out_x,
   output logic [OUT_W-1:0]        rsp_out_y,
   output logic                    rsp_status,
   input  wire logic               csr_write_en,
   input  wire logic               csr_index,
   input  wire logic [6:0]         csr_data
);

   logic [6:0]            points_ff, points_in;
   logic                  looped_ff, looped_in;
   logic                  req_accept;
   logic                  enq_valid;
   entry_type             enq_entry;
   logic [1:0]            inflight;
   entry_type             deq_entry;
   logic                  q_not_empty;
   logic [QCNT_W-1:0]     q_count;
   logic                  back_ready;
   logic                  rsp_valid;
   logic [QCNT_W:0]       occupancy;

   // Configuration registers.
   always_comb begin
      points_in = points_ff;
      looped_in = looped_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_POINTS: points_in = csr_data;
            REG_LOOPED: looped_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= 7'd4;
         looped_ff <= 1'b0;
      end else begin
         points_ff <= points_in;
         looped_ff <= looped_in;
      end
   end

   // Push is refused when the queue could not hold everything in flight.
   assign occupancy  = {1'b0, q_count} + (QCNT_W+1)'(inflight);
   assign full       = (occupancy >= (QCNT_W+1)'(QUEUE_DEPTH));
   assign req_accept = push && !full;

   crspl_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_accept),
      .req_kind        (req_kind),
      .req_point_index (req_point_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_t_pos       (req_t_pos),
      .cfg_points      (points_ff),
      .cfg_looped      (looped_ff),
      .enq_valid       (enq_valid),
      .enq_entry       (enq_entry),
      .inflight        (inflight)
   );

   crspl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (enq_valid),
      .wr_entry  (enq_entry),
      .rd_en     (q_not_empty && back_ready),
      .rd_entry  (deq_entry),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   crspl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_not_empty),
      .in_entry   (deq_entry),
      .in_ready   (back_ready),
      .out_pop    (pop),
      .out_valid  (rsp_valid),
      .out_x      (rsp_out_x),
      .out_y      (rsp_out_y),
      .out_status (rsp_status)
   );

   assign empty = !rsp_valid;

   // The queue never holds more than it was sized for.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      occupancy <= (QCNT_W+1)'(QUEUE_DEPTH))
      else $error("queue occupancy exceeds its depth");

   // A transfer into the queue always finds a free entry.
   a_enq_room: assert property (@(posedge clock) disable iff (reset)
      enq_valid |-> (q_count < QCNT_W'(QUEUE_DEPTH) || (q_not_empty && back_ready)))
      else $error("queue written while full");

   // An index error result carries zero coordinates.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status) |-> (rsp_out_x == '0 && rsp_out_y == '0))
      else $error("error result with nonzero coordinates");

   // No result is shown right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result visible after reset");

endmodule

`default_nettype wire
